/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expects clk and rst in scope.
`define SHS_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");

// Same-cycle implication.
`define SHS_IMPLIES(label, ante, cons) \
  `SHS_CHECK(label, (ante) |-> (cons))

// Next-cycle implication.
`define SHS_NEXT(label, ante, cons) \
  `SHS_CHECK(label, (ante) |=> (cons))

`endif

/* rtl/core/shs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package shs_pkg;

  localparam int BlkWords   = 16;
  localparam int ChainWords = 8;
  localparam int WordBits   = 32;

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;
  localparam logic [5:0] LastByte = 6'd63;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [5:0] XferLast = 6'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_CLOAD,
    ST_ROUND,
    ST_CADD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RU_HOLD,
    RU_SHIFT,
    RU_ROUND
  } ru_op_t;

  typedef struct packed {
    ru_op_t     op;
    logic [5:0] rnd;
  } ru_ctrl_t;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0: r = 32'h6A09E667;
      3'd1: r = 32'hBB67AE85;
      3'd2: r = 32'h3C6EF372;
      3'd3: r = 32'hA54FF53A;
      3'd4: r = 32'h510E527F;
      3'd5: r = 32'h9B05688C;
      3'd6: r = 32'h1F83D9AB;
      default: r = 32'h5BE0CD19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] k_word(input logic [5:0] idx);
    logic [31:0] r;
    case (idx)
      6'd0:  r = 32'h428A2F98; 6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hB5C0FBCF; 6'd3:  r = 32'hE9B5DBA5;
      6'd4:  r = 32'h3956C25B; 6'd5:  r = 32'h59F111F1;
      6'd6:  r = 32'h923F82A4; 6'd7:  r = 32'hAB1C5ED5;
      6'd8:  r = 32'hD807AA98; 6'd9:  r = 32'h12835B01;
      6'd10: r = 32'h243185BE; 6'd11: r = 32'h550C7DC3;
      6'd12: r = 32'h72BE5D74; 6'd13: r = 32'h80DEB1FE;
      6'd14: r = 32'h9BDC06A7; 6'd15: r = 32'hC19BF174;
      6'd16: r = 32'hE49B69C1; 6'd17: r = 32'hEFBE4786;
      6'd18: r = 32'h0FC19DC6; 6'd19: r = 32'h240CA1CC;
      6'd20: r = 32'h2DE92C6F; 6'd21: r = 32'h4A7484AA;
      6'd22: r = 32'h5CB0A9DC; 6'd23: r = 32'h76F988DA;
      6'd24: r = 32'h983E5152; 6'd25: r = 32'hA831C66D;
      6'd26: r = 32'hB00327C8; 6'd27: r = 32'hBF597FC7;
      6'd28: r = 32'hC6E00BF3; 6'd29: r = 32'hD5A79147;
      6'd30: r = 32'h06CA6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27B70A85; 6'd33: r = 32'h2E1B2138;
      6'd34: r = 32'h4D2C6DFC; 6'd35: r = 32'h53380D13;
      6'd36: r = 32'h650A7354; 6'd37: r = 32'h766A0ABB;
      6'd38: r = 32'h81C2C92E; 6'd39: r = 32'h92722C85;
      6'd40: r = 32'hA2BFE8A1; 6'd41: r = 32'hA81A664B;
      6'd42: r = 32'hC24B8B70; 6'd43: r = 32'hC76C51A3;
      6'd44: r = 32'hD192E819; 6'd45: r = 32'hD6990624;
      6'd46: r = 32'hF40E3585; 6'd47: r = 32'h106AA070;
      6'd48: r = 32'h19A4C116; 6'd49: r = 32'h1E376C08;
      6'd50: r = 32'h2748774C; 6'd51: r = 32'h34B0BCB5;
      6'd52: r = 32'h391C0CB3; 6'd53: r = 32'h4ED8AA4A;
      6'd54: r = 32'h5B9CCA4F; 6'd55: r = 32'h682E6FF3;
      6'd56: r = 32'h748F82EE; 6'd57: r = 32'h78A5636F;
      6'd58: r = 32'h84C87814; 6'd59: r = 32'h8CC70208;
      6'd60: r = 32'h90BEFFFA; 6'd61: r = 32'hA4506CEB;
      6'd62: r = 32'hBEF9A3F7;
      default: r = 32'hC67178F2;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

/* rtl/core/shs_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module shs_ram
  import shs_pkg::*;
#(
  parameter int Depth = ChainWords,
  parameter int Width = WordBits
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/shs_round.sv */
`timescale 1ns / 1ps
`default_nettype none
module shs_round
  import shs_pkg::*;
(
  input  wire logic        clk,
  input  wire ru_ctrl_t    ctrl,
  input  wire logic [31:0] shift_word,
  input  wire logic [31:0] blk_word,
  output logic      [31:0] head_word
);

  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [31:0] wt;
  logic [31:0] t1;
  logic [31:0] t2;

  // window holds W[t-16] in w[0] up to W[t-1] in w[15]
  always_comb begin
    if (ctrl.rnd[5:4] == 2'b00) begin
      wt = blk_word;
    end else begin
      wt = sml_sig1(w[14]) + w[9] + sml_sig0(w[1]) + w[0];
    end
    t1 = v[7] + big_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_word(ctrl.rnd) + wt;
    t2 = big_sig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      RU_SHIFT: begin
        for (int i = 0; i < 7; i++) v[i] <= v[i+1];
        v[7] <= shift_word;
      end
      RU_ROUND: begin
        v[0] <= t1 + t2;
        v[1] <= v[0];
        v[2] <= v[1];
        v[3] <= v[2];
        v[4] <= v[3] + t1;
        v[5] <= v[4];
        v[6] <= v[5];
        v[7] <= v[6];
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= wt;
      end
      default: begin
      end
    endcase
  end

  assign head_word = v[0];

endmodule
`default_nettype wire

/* rtl/core/sha256_stream_hasher.sv */
// Channel | Beat contents                                 | Handshake
// input   | data_byte, byte_valid, end_of_message         | in_valid / in_stall
// output  | digest_part0..digest_part3 (256-bit digest)   | out_valid / out_stall
//
// A byte is taken per accepted beat while in_stall is low; a full 64-byte block then
// compresses by chaining-word load, 64 rounds and read-add-write back.
// End of message generates pad and length bytes at one per cycle and runs one or
// two compressions before its digest appears.
// Reset is immediate: no clearing pass; a fresh flag, set by reset and after each final
// block, makes the chaining memory read as the initial hash values until written back.
// in_stall stays high while padding, compressing or holding a finished digest.
// out_stall only delays the handoff of the next digest; the output register holds.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sha256_stream_hasher
  import shs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_valid,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [63:0] digest_part0,
  output logic      [63:0] digest_part1,
  output logic      [63:0] digest_part2,
  output logic      [63:0] digest_part3
);

  localparam int BlkAw   = $clog2(BlkWords);
  localparam int ChainAw = $clog2(ChainWords);

  state_t state, state_next;
  logic [5:0]   cnt;
  logic [5:0]   fill;
  logic [23:0]  acc;
  logic [63:0]  byte_total;
  logic         pad_active, pad_mark, pad_len, final_blk, chain_fresh;
  logic [255:0] dig_acc;

  logic         in_accept, byte_en, blk_we, chain_we, handoff;
  logic [7:0]   len_byte, pad_byte, new_byte;
  logic [63:0]  bits;
  logic [BlkAw-1:0]   blk_raddr;
  logic [31:0]        blk_rdata;
  logic [ChainAw-1:0] chain_raddr, chain_waddr;
  logic [31:0]        chain_rdata, chain_word, head_word, sum;
  ru_ctrl_t           ru_ctrl;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign handoff   = (state == ST_DONE) && (!out_valid || !out_stall);

  assign bits     = {byte_total[60:0], 3'b000};
  assign len_byte = 8'(bits >> {~fill[2:0], 3'b000});
  assign pad_byte = !pad_mark ? PadMark :
                    (pad_len || fill == LenStart) ? len_byte : 8'h00;
  assign new_byte = (state == ST_PAD) ? pad_byte : data_byte;
  assign byte_en  = (state == ST_PAD) || (in_accept && byte_valid);
  assign blk_we   = byte_en && (fill[1:0] == 2'd3);

  assign blk_raddr   = (state == ST_ROUND) ? cnt[BlkAw-1:0] + 1'b1 : '0;
  assign chain_raddr = cnt[ChainAw-1:0];
  assign chain_waddr = cnt[ChainAw-1:0] - 1'b1;
  // unwritten chaining words read as the initial hash values
  assign chain_word  = chain_fresh ? iv_word(chain_waddr) : chain_rdata;
  assign sum         = chain_word + head_word;
  assign chain_we    = (state == ST_CADD) && (cnt != 6'd0);

  always_comb begin
    ru_ctrl.rnd = cnt;
    if (state == ST_ROUND) begin
      ru_ctrl.op = RU_ROUND;
    end else if ((state == ST_CLOAD || state == ST_CADD) && cnt != 6'd0) begin
      ru_ctrl.op = RU_SHIFT;
    end else begin
      ru_ctrl.op = RU_HOLD;
    end
  end

  shs_ram #(.Depth(BlkWords), .Width(WordBits)) u_blk (
    .clk   (clk),
    .we    (blk_we),
    .waddr (fill[5:2]),
    .wdata ({acc, new_byte}),
    .raddr (blk_raddr),
    .rdata (blk_rdata)
  );

  shs_ram #(.Depth(ChainWords), .Width(WordBits)) u_chain (
    .clk   (clk),
    .we    (chain_we),
    .waddr (chain_waddr),
    .wdata (sum),
    .raddr (chain_raddr),
    .rdata (chain_rdata)
  );

  shs_round u_round (
    .clk        (clk),
    .ctrl       (ru_ctrl),
    .shift_word (chain_word),
    .blk_word   (blk_rdata),
    .head_word  (head_word)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (byte_valid && fill == LastByte) state_next = ST_CLOAD;
          else if (end_of_message) state_next = ST_PAD;
        end
      end
      ST_PAD:   if (fill == LastByte) state_next = ST_CLOAD;
      ST_CLOAD: if (cnt == XferLast) state_next = ST_ROUND;
      ST_ROUND: if (cnt == LastRound) state_next = ST_CADD;
      ST_CADD: begin
        if (cnt == XferLast) begin
          if (final_blk) state_next = ST_DONE;
          else if (pad_active) state_next = ST_PAD;
          else state_next = ST_IDLE;
        end
      end
      ST_DONE:  if (handoff) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      fill        <= '0;
      byte_total  <= '0;
      pad_active  <= 1'b0;
      pad_mark    <= 1'b0;
      pad_len     <= 1'b0;
      final_blk   <= 1'b0;
      chain_fresh <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? 6'd0 : cnt + 6'd1;

      if (byte_en) begin
        fill <= fill + 6'd1;
      end
      if (in_accept && byte_valid) begin
        byte_total <= byte_total + 64'd1;
      end
      if (in_accept && end_of_message) begin
        pad_active <= 1'b1;
      end
      if (state == ST_PAD) begin
        pad_mark <= 1'b1;
        if (pad_mark && fill == LenStart) pad_len <= 1'b1;
      end
      if (state != ST_CLOAD && state_next == ST_CLOAD) begin
        final_blk <= (state == ST_PAD) && pad_len;
      end
      if (state == ST_CADD && cnt == XferLast) begin
        chain_fresh <= final_blk;
      end

      if (handoff) begin
        out_valid  <= 1'b1;
        byte_total <= '0;
        pad_active <= 1'b0;
        pad_mark   <= 1'b0;
        pad_len    <= 1'b0;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (byte_en) begin
      acc <= {acc[15:0], new_byte};
    end
    if (chain_we) begin
      dig_acc <= {dig_acc[223:0], sum};
    end
    if (handoff) begin
      digest_part0 <= dig_acc[255:192];
      digest_part1 <= dig_acc[191:128];
      digest_part2 <= dig_acc[127:64];
      digest_part3 <= dig_acc[63:0];
    end
  end

  `SHS_NEXT(a_round_end, state == ST_ROUND && cnt == LastRound, state == ST_CADD && cnt == 6'd0)
  `SHS_IMPLIES(a_blk_write_ctx, blk_we, state == ST_IDLE || state == ST_PAD)
  `SHS_IMPLIES(a_compress_aligned, state == ST_CLOAD, fill == 6'd0)
  `SHS_IMPLIES(a_done_fresh, state == ST_DONE, chain_fresh)

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] data_byte = 8'h00;
  logic byte_valid = 1'b0;
  logic end_of_message = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] digest_part0, digest_part1, digest_part2, digest_part3;

  sha256_stream_hasher uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .byte_valid(byte_valid), .end_of_message(end_of_message),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_part0(digest_part0), .digest_part1(digest_part1),
    .digest_part2(digest_part2), .digest_part3(digest_part3)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [31:0] hash_h[8];
  logic [7:0]  blk[64];
  int unsigned blk_fill;
  logic [63:0] msg_len;
  logic [255:0] digest_q[$];
  int errors = 0;
  int beats = 0;
  bit no_idle = 0;
  bit drained = 0;

  localparam logic [31:0] IV[8] = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
  localparam logic [31:0] KR[64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
    32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
    32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
    32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
    32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
    32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

  localparam int EDGE_LENS[6] = '{55, 56, 63, 64, 119, 120};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 64; t++) begin
      if (t < 16) w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      else w[t] = w[t-16] + w[t-7]
          + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
          + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
    end
    v = hash_h;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
          + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KR[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
          + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endtask

  task automatic hash_restart();
    hash_h = IV;
    blk_fill = 0;
    msg_len = '0;
  endtask

  task automatic hash_step(input logic [7:0] b, input logic bv, input logic eom);
    logic [63:0] bits;
    if (bv) begin
      blk[blk_fill] = b;
      blk_fill++;
      msg_len++;
      if (blk_fill == 64) begin
        compress();
        blk_fill = 0;
      end
    end
    if (eom) begin
      bits = msg_len << 3;
      blk[blk_fill] = 8'h80;
      blk_fill++;
      if (blk_fill > 56) begin
        while (blk_fill < 64) blk[blk_fill++] = 8'h00;
        compress();
        blk_fill = 0;
      end
      while (blk_fill < 56) blk[blk_fill++] = 8'h00;
      for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
      compress();
      digest_q.push_back({hash_h[0], hash_h[1], hash_h[2], hash_h[3],
                          hash_h[4], hash_h[5], hash_h[6], hash_h[7]});
      hash_restart();
    end
  endtask

  // send one beat; a nonzero typed digest is also checked against the predictor
  task automatic send_beat(input logic [7:0] b, input logic bv, input logic eom,
                           input logic [255:0] typed);
    int gap;
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    byte_valid <= bv;
    end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats++;
    hash_step(b, bv, eom);
    if (typed != '0 && digest_q[$] !== typed) begin
      errors++;
      if (errors <= 10) $display("predictor digest %h, typed %h", digest_q[$], typed);
    end
  endtask

  // random stall on the digest side
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!no_idle && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    logic [255:0] got;
    if (!rst && out_valid && !out_stall) begin
      got = {digest_part0, digest_part1, digest_part2, digest_part3};
      if (digest_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected digest %h", got);
      end else begin
        if (got !== digest_q[0]) begin
          errors++;
          if (errors <= 10) $display("digest mismatch: expected %h got %h", digest_q[0], got);
        end
        void'(digest_q.pop_front());
      end
    end
  end

  typedef struct {
    logic [7:0] b;
    logic bv;
    logic eom;
    logic [255:0] typed;
  } beat_row_t;

  localparam logic [255:0] DG_EMPTY =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] DG_ABC =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  beat_row_t rows[10] = '{
    '{8'h00, 1'b0, 1'b1, DG_EMPTY},   // empty message
    '{8'h55, 1'b0, 1'b0, '0},        // neither flag: ignored
    '{8'h61, 1'b1, 1'b0, '0},
    '{8'h62, 1'b1, 1'b0, '0},
    '{8'h63, 1'b1, 1'b1, DG_ABC},     // byte and end together
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'hAA, 1'b0, 1'b1, '0},         // end with no byte after a tail
    '{8'hFF, 1'b1, 1'b1, '0},
    '{8'h00, 1'b1, 1'b1, '0}
  };

  task automatic send_msg(input int len, input bit end_with_byte);
    for (int i = 0; i < len; i++)
      send_beat(8'($urandom_range(0, 255)), 1'b1, end_with_byte && i == len - 1, '0);
    if (!end_with_byte || len == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, '0);
  endtask

  initial begin
    int len;
    hash_restart();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send_beat(rows[i].b, rows[i].bv, rows[i].eom, rows[i].typed);
    // lengths around the padding edges
    foreach (EDGE_LENS[i]) send_msg(EDGE_LENS[i], (i % 2) == 1);
    while (beats < 1350) begin
      if (beats > 1100) no_idle = 1;
      case ($urandom_range(0, 9))
        0: len = $urandom_range(52, 70);
        1: len = $urandom_range(0, 130);
        2: begin
          send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
          len = -1;
        end
        default: len = $urandom_range(0, 20);
      endcase
      if (len >= 0) begin
        send_msg(len, $urandom_range(0, 1) == 1);
      end
      // let the digest side drain once before carrying on
      if (beats > 600 && !drained) begin
        drained = 1;
        in_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
